// File: src/bitmap_frame_allocator_assert.svh
// ----------------------------------------------------------------------------
// Bitmap frame allocator assertion macros
// Shared property forms for the allocator modules, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bfa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator package
// Types and constants shared by the allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

    localparam int ADDR_W    = 32;
    localparam int MAP_W     = 8;
    localparam int BIT_SEL_W = 3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_SCAN,
        ST_MUL,
        ST_OUT
    } t_state;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef struct packed {
        logic              valid;
        logic              granted;
        logic [ADDR_W-1:0] address;
    } t_result;

endpackage

`default_nettype wire

// File: src/bfa_ram.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator RAM
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/bfa_div.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator divider
// Divides by the constant page size through a multiplication by its rounded-up
// reciprocal, split into two partial products; the dividend, the partial products
// and the quotient are registered in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module bfa_div
    import bfa_pkg::*;
#(
    parameter int DIVISOR = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [ADDR_W-1:0] i_dividend,
    output logic                   o_done,
    output logic      [ADDR_W-1:0] o_quotient
);

    localparam int SH     = $clog2(DIVISOR);
    localparam int LO_W   = 17;
    localparam int HI_W   = 16;
    localparam int LP_W   = ADDR_W + LO_W;
    localparam int HP_W   = ADDR_W + HI_W;
    localparam int PROD_W = ADDR_W + LO_W + HI_W;
    localparam logic [63:0] RECIP_C =
        ((64'd1 << (ADDR_W + SH)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [LO_W-1:0] RECIP_LO = RECIP_C[LO_W-1:0];
    localparam logic [HI_W-1:0] RECIP_HI = RECIP_C[LO_W +: HI_W];

    logic              r_mul;
    logic              r_add;
    logic              r_done;
    logic [ADDR_W-1:0] r_a;
    logic [LP_W-1:0]   r_lo;
    logic [HP_W-1:0]   r_hi;
    logic [ADDR_W-1:0] r_quo;
    logic [PROD_W-1:0] w_sum;
    logic [PROD_W-1:0] w_shift;

    assign w_sum   = {r_hi, {LO_W{1'b0}}} + PROD_W'(r_lo);
    assign w_shift = w_sum >> (ADDR_W + SH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= 1'b0;
            r_add  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_mul  <= i_start;
            r_add  <= r_mul;
            r_done <= r_add;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_dividend;
        end
        if (r_mul) begin
            r_lo <= LP_W'(r_a) * LP_W'(RECIP_LO);
            r_hi <= HP_W'(r_a) * HP_W'(RECIP_HI);
        end
        if (r_add) begin
            r_quo <= w_shift[ADDR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: src/bfa_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator controller
// Sequencer for the map clearing pass, the first-fit scan and the frame free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_frame_allocator_assert.svh"

module bfa_ctrl
    import bfa_pkg::*;
#(
    parameter int MAP_BYTES  = 128,
    parameter int PAGE_BYTES = 4096,
    parameter int AW         = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_op,
    input  wire logic [ADDR_W-1:0] i_addr,
    output logic                   o_ram_we,
    output logic      [AW-1:0]     o_ram_waddr,
    output logic      [MAP_W-1:0]  o_ram_wdata,
    output logic                   o_ram_re,
    output logic      [AW-1:0]     o_ram_raddr,
    input  wire logic [MAP_W-1:0]  i_ram_rdata,
    output logic                   o_div_start,
    output logic      [ADDR_W-1:0] o_div_dividend,
    input  wire logic              i_div_done,
    input  wire logic [ADDR_W-1:0] i_div_quotient,
    output t_result                o_res,
    input  wire logic              i_res_ready
);

    localparam int FW = AW + BIT_SEL_W;
    localparam int PW = $clog2(PAGE_BYTES + 1);
    localparam logic [AW-1:0]     LAST_IDX = AW'(MAP_BYTES - 1);
    localparam logic [ADDR_W-1:0] FRAMES   = ADDR_W'(MAP_BYTES * MAP_W);

    function automatic logic [BIT_SEL_W-1:0] lowest_zero(input logic [MAP_W-1:0] v);
        logic [BIT_SEL_W-1:0] k;
        k = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (!v[i]) begin
                k = BIT_SEL_W'(i);
            end
        end
        return k;
    endfunction

    t_state               r_state, n_state;
    logic [AW-1:0]        r_ptr, n_ptr;
    logic [AW-1:0]        r_chk, n_chk;
    logic                 r_pend, n_pend;
    logic                 r_iss_done, n_iss_done;
    logic [BIT_SEL_W-1:0] r_bit, n_bit;
    logic [FW-1:0]        r_frame, n_frame;
    logic                 r_granted, n_granted;
    logic [ADDR_W-1:0]    r_addr, n_addr;

    logic [BIT_SEL_W-1:0] w_k;
    logic [FW+PW-1:0]     w_prod;

    assign w_k    = lowest_zero(i_ram_rdata);
    assign w_prod = (FW + PW)'(r_frame) * (FW + PW)'(PAGE_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_ptr      <= '0;
            r_pend     <= 1'b0;
            r_iss_done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ptr      <= n_ptr;
            r_pend     <= n_pend;
            r_iss_done <= n_iss_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk     <= n_chk;
        r_bit     <= n_bit;
        r_frame   <= n_frame;
        r_granted <= n_granted;
        r_addr    <= n_addr;
    end

    always_comb begin
        n_state        = r_state;
        n_ptr          = r_ptr;
        n_chk          = r_chk;
        n_pend         = r_pend;
        n_iss_done     = r_iss_done;
        n_bit          = r_bit;
        n_frame        = r_frame;
        n_granted      = r_granted;
        n_addr         = r_addr;
        o_in_ready     = 1'b0;
        o_ram_we       = 1'b0;
        o_ram_waddr    = r_ptr;
        o_ram_wdata    = '0;
        o_ram_re       = 1'b0;
        o_ram_raddr    = r_ptr;
        o_div_start    = 1'b0;
        o_div_dividend = i_addr;
        o_res.valid    = 1'b0;
        o_res.granted  = r_granted;
        o_res.address  = r_addr;
        case (r_state)
            ST_CLEAR: begin
                o_ram_we = 1'b1;
                if (r_ptr == LAST_IDX) begin
                    n_ptr   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_ptr = AW'(r_ptr + 1'b1);
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_op == OP_FREE) begin
                        o_div_start = 1'b1;
                        n_state     = ST_DIV;
                    end else begin
                        n_ptr      = '0;
                        n_pend     = 1'b0;
                        n_iss_done = 1'b0;
                        n_state    = ST_SCAN;
                    end
                end
            end
            ST_DIV: begin
                if (i_div_done) begin
                    if (i_div_quotient < FRAMES) begin
                        n_ptr   = i_div_quotient[BIT_SEL_W +: AW];
                        n_bit   = i_div_quotient[BIT_SEL_W-1:0];
                        n_state = ST_FREE_RD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FREE_RD: begin
                o_ram_re = 1'b1;
                n_state  = ST_FREE_WR;
            end
            ST_FREE_WR: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = i_ram_rdata & ~(MAP_W'(1) << r_bit);
                n_state     = ST_IDLE;
            end
            ST_SCAN: begin
                if (r_pend && (i_ram_rdata != {MAP_W{1'b1}})) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_chk;
                    o_ram_wdata = i_ram_rdata | (MAP_W'(1) << w_k);
                    n_frame     = {r_chk, w_k};
                    n_state     = ST_MUL;
                end else if (r_pend && (r_chk == LAST_IDX)) begin
                    n_granted = 1'b0;
                    n_addr    = '0;
                    n_state   = ST_OUT;
                end else if (!r_iss_done) begin
                    o_ram_re = 1'b1;
                    n_chk    = r_ptr;
                    n_pend   = 1'b1;
                    if (r_ptr == LAST_IDX) begin
                        n_iss_done = 1'b1;
                    end else begin
                        n_ptr = AW'(r_ptr + 1'b1);
                    end
                end else begin
                    n_pend = 1'b0;
                end
            end
            ST_MUL: begin
                n_granted = 1'b1;
                n_addr    = ADDR_W'(w_prod);
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                o_res.valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `BFA_ASSERT_IMPL(a_scan_claims_free, (r_state == ST_SCAN) && o_ram_we, i_ram_rdata != {MAP_W{1'b1}}, "scan wrote back a full byte")
    `BFA_ASSERT_IMPL(a_miss_zero_addr, o_res.valid && !o_res.granted, o_res.address == '0, "refused allocation carries a nonzero address")
    `BFA_ASSERT_IMPL(a_div_done_in_div, i_div_done, r_state == ST_DIV, "divider finished outside the free sequence")

endmodule

`default_nettype wire

// File: src/bitmap_frame_allocator.sv
// Allocate: the scan reads one map byte a cycle and grants the lowest free frame of the first
// map byte that is not full, at frame * PAGE_BYTES; a full map gives a refusal with address 0.
// Free: no result; the address is divided by PAGE_BYTES through a reciprocal multiply, and
// the frame's bit is cleared unless the frame lies past the map.
// One item at a time; a finished result waits in the output register while the next is taken.
// Reset (synchronous, active low) starts a clearing pass that zeroes every map byte, with no input taken.
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// First-fit physical page-frame allocator over a used-frame bitmap in RAM.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_frame_allocator_assert.svh"

module bitmap_frame_allocator
    import bfa_pkg::*;
#(
    parameter int MAP_BYTES  = 128,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [ADDR_W-1:0] s_axis_tdata,   // [31:0] free_address
    input  wire logic              s_axis_tuser,   // [0] operation
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [ADDR_W-1:0] m_axis_tdata,   // [31:0] frame_address
    output logic                   m_axis_tuser    // [0] granted
);

    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

    logic              w_ram_we;
    logic [AW-1:0]     w_ram_waddr;
    logic [MAP_W-1:0]  w_ram_wdata;
    logic              w_ram_re;
    logic [AW-1:0]     w_ram_raddr;
    logic [MAP_W-1:0]  w_ram_rdata;
    logic              w_div_start;
    logic [ADDR_W-1:0] w_div_dividend;
    logic              w_div_done;
    logic [ADDR_W-1:0] w_div_quotient;
    t_result           w_res;
    logic              w_res_ready;

    logic              r_m_valid;
    logic              r_m_granted;
    logic [ADDR_W-1:0] r_m_addr;

    bfa_ram #(
        .WIDTH (MAP_W),
        .DEPTH (MAP_BYTES),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    bfa_div #(
        .DIVISOR (PAGE_BYTES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .o_done     (w_div_done),
        .o_quotient (w_div_quotient)
    );

    bfa_ctrl #(
        .MAP_BYTES  (MAP_BYTES),
        .PAGE_BYTES (PAGE_BYTES),
        .AW         (AW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_op           (s_axis_tuser),
        .i_addr         (s_axis_tdata),
        .o_ram_we       (w_ram_we),
        .o_ram_waddr    (w_ram_waddr),
        .o_ram_wdata    (w_ram_wdata),
        .o_ram_re       (w_ram_re),
        .o_ram_raddr    (w_ram_raddr),
        .i_ram_rdata    (w_ram_rdata),
        .o_div_start    (w_div_start),
        .o_div_dividend (w_div_dividend),
        .i_div_done     (w_div_done),
        .i_div_quotient (w_div_quotient),
        .o_res          (w_res),
        .i_res_ready    (w_res_ready)
    );

    assign w_res_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_m_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid && w_res_ready) begin
            r_m_granted <= w_res.granted;
            r_m_addr    <= w_res.address;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_granted;
    assign m_axis_tdata  = r_m_addr;

    `BFA_ASSERT_NEXT(a_res_waits, w_res.valid && !w_res_ready, w_res.valid, "stalled result lost")

endmodule

`default_nettype wire
